// ===== hdl/mpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpt_pkg
// Types and constants shared by the path table block.
// ----------------------------------------------------------------------------
package mpt_pkg;

    localparam int CAPACITY      = 8;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam logic [15:0] NO_ROUTE_HOPS = 16'd255;
    localparam logic [15:0] HOP_CEIL      = 16'hffff;
    localparam logic [33:0] ENERGY_START  = 34'd10000000000;
    // one stored path: nh, lh, hops, iface, energy, distance, delay
    localparam int ENTRY_W = 32 + 32 + 16 + 32 + 32 + 32 + 64;

    localparam logic [3:0] ACT_INSERT   = 4'd0;
    localparam logic [3:0] ACT_FIND_NH  = 4'd1;
    localparam logic [3:0] ACT_FIND_PR  = 4'd2;
    localparam logic [3:0] ACT_DISJOINT = 4'd3;
    localparam logic [3:0] ACT_FIND_LH  = 4'd4;
    localparam logic [3:0] ACT_DEL_NH   = 4'd5;
    localparam logic [3:0] ACT_DEL_IF   = 4'd6;
    localparam logic [3:0] ACT_CLEAR    = 4'd7;
    localparam logic [3:0] ACT_DEL_WST  = 4'd8;
    localparam logic [3:0] ACT_TRIM     = 4'd9;
    localparam logic [3:0] ACT_MINHOP_P = 4'd10;
    localparam logic [3:0] ACT_MAX_HOPS = 4'd11;
    localparam logic [3:0] ACT_MIN_HOPS = 4'd12;

    localparam logic [1:0] MODE_DIST   = 2'd0;
    localparam logic [1:0] MODE_ENERGY = 2'd1;
    localparam logic [1:0] MODE_DELAY  = 2'd2;

    localparam logic [0:0] REG_MODE = 1'd0;
    localparam logic [0:0] REG_MAXP = 1'd1;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] next_hop;
        logic [31:0] last_hop;
        logic [15:0] hop_count;
        logic [31:0] iface_addr;
        logic [31:0] residual_energy;
        logic [31:0] squared_distance;
        logic [63:0] path_delay;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_hop;
        logic [31:0] last_hop;
        logic [15:0] hop_count;
        logic [31:0] iface_addr;
        logic [31:0] energy;
        logic [31:0] distance;
        logic [63:0] delay;
    } t_entry;

    typedef struct packed {
        logic        found;
        logic [2:0]  slot;
        logic [31:0] out_next_hop;
        logic [31:0] out_last_hop;
        logic [15:0] out_hop_count;
        logic [31:0] out_energy;
        logic [31:0] out_distance;
        logic [63:0] out_delay;
        logic [3:0]  path_count;
        logic [15:0] hop_result;
        logic        rejected;
        logic [3:0]  removed_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_COMPACT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       metric_mode;
        logic [3:0]       max_paths;
    } t_cfg;

endpackage

// ===== hdl/mpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/mpt_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpt_cfg
// APB register file for metric mode and trim limit.
// ----------------------------------------------------------------------------
module mpt_cfg import mpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    logic [1:0] r_mode;
    logic [3:0] r_maxp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DIST;
            r_maxp <= 4'd3;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MODE: r_mode <= pwdata[1:0];
                REG_MAXP: r_maxp <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MODE: prdata = {30'd0, r_mode};
            REG_MAXP: prdata = {28'd0, r_maxp};
            default:  prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = '{metric_mode: r_mode, max_paths: r_maxp};
endmodule

// ===== hdl/mpt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpt_ctrl
// Sequencer: scans the entry memory one slot a cycle, compacts on deletion.
// ----------------------------------------------------------------------------
module mpt_ctrl import mpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    input  t_cfg                 i_cfg,
    output logic                 o_we,
    output logic [IDX_W-1:0]     o_waddr,
    output t_entry               o_wdata,
    output logic [IDX_W-1:0]     o_raddr,
    input  t_entry               i_rdata,
    output logic                 o_valid,
    output t_out_item            o_item
);
    t_state              r_state, n_state;
    t_in_item            r_in;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_rd, n_rd;       // slot being read
    logic [CNT_W-1:0]    r_wr, n_wr;       // compaction write pointer
    logic [CNT_W-1:0]    r_ix, n_ix;       // slot of data in rd
    logic [3:0]          r_gone, n_gone;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_slot, n_slot;
    t_entry              r_pick, n_pick;
    logic [64:0]         r_best, n_best;
    logic [15:0]         r_hop, n_hop;
    logic                r_trim, n_trim;   // trim round in progress
    logic                r_wpass, n_wpass; // compaction of worst slot
    t_out_item           r_out, n_out;
    logic                r_valid, n_valid;
    logic                r_fwd;            // slot read was written in the same cycle
    t_entry              r_fwd_data;
    t_entry              rd;
    logic                hit, drop;
    logic [64:0]         metric;

    // take the written data when the slot read was written in the same cycle
    assign rd = r_fwd ? r_fwd_data : i_rdata;

    always_comb begin
        case (i_cfg.metric_mode)
            MODE_DIST:   metric = {33'd0, rd.distance};
            MODE_ENERGY: metric = {33'd0, rd.energy};
            default:     metric = {1'b0, rd.delay};
        endcase
        case (r_in.action)
            ACT_FIND_NH: hit = rd.next_hop == r_in.next_hop;
            ACT_FIND_PR: hit = rd.next_hop == r_in.next_hop
                            && rd.last_hop == r_in.last_hop;
            ACT_FIND_LH: hit = rd.last_hop == r_in.next_hop;
            ACT_DISJOINT: hit = rd.next_hop == r_in.next_hop
                            || rd.last_hop == r_in.last_hop;
            default:     hit = 1'b0;
        endcase
        if (r_wpass) begin
            drop = r_ix[IDX_W-1:0] == r_slot && r_ix == {1'b0, r_slot};
        end else if (r_in.action == ACT_DEL_NH) begin
            drop = rd.next_hop == r_in.next_hop;
        end else begin
            drop = rd.iface_addr == r_in.iface_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_fwd   <= o_we && (o_waddr == o_raddr);
        end
        if (start && !busy) begin
            r_in <= i_item;
        end
        r_fwd_data <= o_wdata;
        r_rd <= n_rd; r_wr <= n_wr; r_ix <= n_ix; r_gone <= n_gone;
        r_found <= n_found; r_slot <= n_slot; r_pick <= n_pick;
        r_best <= n_best; r_hop <= n_hop; r_trim <= n_trim;
        r_wpass <= n_wpass; r_out <= n_out;
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_rd = r_rd; n_wr = r_wr;
        n_ix = r_rd; n_gone = r_gone; n_found = r_found; n_slot = r_slot;
        n_pick = r_pick; n_best = r_best; n_hop = r_hop; n_trim = r_trim;
        n_wpass = r_wpass; n_out = r_out; n_valid = 1'b0;
        o_we = 1'b0; o_waddr = r_wr[IDX_W-1:0]; o_wdata = rd;
        o_raddr = r_rd[IDX_W-1:0];
        busy = r_state != ST_IDLE;
        case (r_state)
            ST_IDLE: begin
                o_raddr = '0;
                n_rd = {{(CNT_W-1){1'b0}}, 1'b1}; n_wr = '0; n_gone = '0;
                n_found = 1'b0; n_slot = '0; n_pick = '0;
                n_best = (i_cfg.metric_mode == MODE_ENERGY) ? 65'(ENERGY_START) : '0;
                n_trim = 1'b0; n_wpass = 1'b0;
                n_hop = (i_item.action == ACT_MINHOP_P) ? HOP_CEIL
                      : (i_item.action == ACT_MIN_HOPS) ? NO_ROUTE_HOPS : '0;
                if (start) begin
                    n_state = ST_SCAN;
                    if (i_item.action == ACT_INSERT) begin
                        n_state = ST_DONE;
                        if (r_count != CNT_W'(CAPACITY)) begin
                            o_we = 1'b1; o_waddr = r_count[IDX_W-1:0];
                            o_wdata = '{i_item.next_hop, i_item.last_hop,
                                i_item.hop_count, i_item.iface_addr,
                                i_item.residual_energy, i_item.squared_distance,
                                i_item.path_delay};
                            n_found = 1'b1; n_slot = r_count[IDX_W-1:0];
                            n_pick = o_wdata; n_count = r_count + 1'b1;
                        end
                    end else if (i_item.action == ACT_CLEAR) begin
                        n_state = ST_DONE; n_gone = 4'(r_count); n_count = '0;
                    end else if (i_item.action > ACT_MIN_HOPS || r_count == '0
                                 || (i_item.action == ACT_TRIM
                                     && r_count <= CNT_W'(i_cfg.max_paths))
                                 || ((i_item.action == ACT_DEL_WST
                                      || i_item.action == ACT_TRIM)
                                     && i_cfg.metric_mode > MODE_DELAY)) begin
                        n_state = ST_DONE;
                    end
                    n_trim = i_item.action == ACT_TRIM;
                    n_found = n_found || (i_item.action == ACT_DISJOINT);
                end
            end
            ST_SCAN, ST_COMPACT: begin
                // rd holds slot r_ix; keep reading ahead
                if (r_state == ST_COMPACT) begin
                    if (drop) begin
                        n_gone = r_gone + 1'b1;
                    end else begin
                        o_we = 1'b1; n_wr = r_wr + 1'b1;
                    end
                end else begin
                    case (r_in.action)
                        ACT_FIND_NH, ACT_FIND_PR, ACT_FIND_LH: begin
                            if (hit && !r_found) begin
                                n_found = 1'b1; n_slot = r_ix[IDX_W-1:0];
                                n_pick = rd;
                            end
                        end
                        ACT_DISJOINT: if (hit) n_found = 1'b0;
                        ACT_DEL_WST, ACT_TRIM: begin
                            if ((i_cfg.metric_mode == MODE_ENERGY)
                                ? metric < r_best : metric > r_best) begin
                                n_best = metric; n_found = 1'b1;
                                n_slot = r_ix[IDX_W-1:0]; n_pick = rd;
                            end
                        end
                        ACT_MINHOP_P: begin
                            if (rd.hop_count < r_hop) begin
                                n_hop = rd.hop_count; n_found = 1'b1;
                                n_slot = r_ix[IDX_W-1:0]; n_pick = rd;
                            end
                        end
                        ACT_MAX_HOPS: if (rd.hop_count > r_hop)
                                          n_hop = rd.hop_count;
                        ACT_MIN_HOPS: if (rd.hop_count < r_hop)
                                          n_hop = rd.hop_count;
                        ACT_DEL_NH, ACT_DEL_IF: begin
                            if (drop) n_gone = r_gone + 1'b1;
                            else begin o_we = 1'b1; n_wr = r_wr + 1'b1; end
                        end
                        default: ;
                    endcase
                end
                n_rd = r_rd + 1'b1;
                if (r_ix + 1'b1 >= r_count) begin
                    n_state = ST_DONE;
                    if (r_state == ST_COMPACT || r_in.action == ACT_DEL_NH
                        || r_in.action == ACT_DEL_IF) begin
                        n_count = r_wr + (o_we ? 1'b1 : 1'b0);
                        n_wpass = 1'b0;
                        if (r_trim && n_count > CNT_W'(i_cfg.max_paths)) begin
                            n_state = ST_SCAN; // next trim round
                            n_found = 1'b0; n_rd = {{(CNT_W-1){1'b0}}, 1'b1};
                            n_best = (i_cfg.metric_mode == MODE_ENERGY)
                                   ? 65'(ENERGY_START) : '0;
                        end
                    end else if ((r_in.action == ACT_DEL_WST || r_trim)
                                 && n_found) begin
                        n_state = ST_COMPACT; n_wpass = 1'b1; n_wr = '0;
                        n_rd = {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                    if (n_state != ST_DONE) o_raddr = '0;
                end
            end
            ST_DONE: begin
                n_valid = 1'b1; n_state = ST_IDLE;
                n_out = '0;
                n_out.path_count = 4'(r_count);
                n_out.removed_count = r_gone;
                n_out.rejected = r_in.action == ACT_INSERT && !r_found;
                if (r_in.action == ACT_DISJOINT) begin
                    n_out.found = r_found;
                end else if (r_found && !r_trim) begin
                    n_out.found = 1'b1; n_out.slot = 3'(r_slot);
                    n_out.out_next_hop = r_pick.next_hop;
                    n_out.out_last_hop = r_pick.last_hop;
                    n_out.out_hop_count = r_pick.hop_count;
                    n_out.out_energy = r_pick.energy;
                    n_out.out_distance = r_pick.distance;
                    n_out.out_delay = r_pick.delay;
                end
                if (r_in.action == ACT_MAX_HOPS) begin
                    n_out.hop_result = (r_hop == '0) ? NO_ROUTE_HOPS : r_hop;
                end else if (r_in.action == ACT_MIN_HOPS) begin
                    n_out.hop_result = r_hop;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_IDLE) n_ix = '0;
        if (n_state == ST_SCAN && r_state != ST_IDLE && o_raddr == '0) n_ix = '0;
        if (n_state == ST_COMPACT && r_state == ST_SCAN) n_ix = '0;
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && r_state == ST_IDLE) |-> (start && i_item.action == ACT_INSERT))
        else $error("write while idle without insert");
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_valid) else $error("missing result");
`endif
endmodule

// ===== hdl/multipath_path_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipath_path_table_unit
// Ordered path list with lookup, deletion and worst-path trimming.
// ----------------------------------------------------------------------------
// One item at a time. Insert and clear go straight to the done state; a
// scan reads the stored paths in order; a delete by next hop or interface
// compacts during its scan; delete worst is a scan then a compaction pass;
// trim repeats that per removed path. The single-read-port entry memory sets
// the pace. The result strobe lasts one cycle and cannot be held off.
module multipath_path_table_unit import mpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg             cfg;
    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    t_entry           wdata, rdata;

    mpt_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    mpt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    mpt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .i_cfg(cfg),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .o_raddr(raddr),
        .i_rdata(rdata), .o_valid(o_strobe), .o_item
    );
endmodule

// ===== tb/sv/tb_multipath_path_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multipath_path_table_unit
// Self-checking bench for the ordered path table.
// ----------------------------------------------------------------------------
// Items are sent through the start/busy handshake. A path-list tracker
// predicts each result and compares it field by field. The APB port changes
// the worst-path metric and the trim size between phases. Sender idling
// varies per phase.
module tb_multipath_path_table_unit;
    import mpt_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          ITEMS_PHASE  = 475;
    localparam int          DRAIN_CYCLES = 200;
    localparam logic [63:0] ENERGY_CEIL  = 64'd10000000000;
    localparam logic [3:0]  ACT_SPARE_LO = ACT_MIN_HOPS + 4'd1;
    localparam logic [3:0]  ACT_SPARE_HI = 4'hf;

    class path_list_tracker;
        t_entry      paths[CAPACITY];
        int unsigned n_paths;
        logic [1:0]  mode;
        logic [3:0]  keep;
        t_out_item   pending[$];
        int unsigned errors;

        function new();
            n_paths = 0;
            mode    = MODE_DIST;
            keep    = 4'd3;
            errors  = 0;
        endfunction

        function void set_cfg(logic addr, logic [31:0] value);
            if (addr == REG_MODE) mode = value[1:0];
            else keep = value[3:0];
        endfunction

        function void report(ref t_out_item r, input int unsigned k);
            r.found         = 1'b1;
            r.slot          = k[2:0];
            r.out_next_hop  = paths[k].next_hop;
            r.out_last_hop  = paths[k].last_hop;
            r.out_hop_count = paths[k].hop_count;
            r.out_energy    = paths[k].energy;
            r.out_distance  = paths[k].distance;
            r.out_delay     = paths[k].delay;
        endfunction

        function void drop(int unsigned k);
            for (int unsigned j = k; j + 1 < n_paths; j++) paths[j] = paths[j + 1];
            n_paths--;
        endfunction

        // first path with the worst metric; a later tie does not replace it
        function int unsigned worst();
            logic [63:0] best, m;
            int unsigned pick;
            pick = CAPACITY;
            best = (mode == MODE_ENERGY) ? ENERGY_CEIL : 64'd0;
            if (mode > MODE_DELAY) return CAPACITY;
            for (int unsigned k = 0; k < n_paths; k++) begin
                m = (mode == MODE_DIST) ? {32'd0, paths[k].distance}
                  : (mode == MODE_ENERGY) ? {32'd0, paths[k].energy} : paths[k].delay;
                if ((mode != MODE_ENERGY && m > best) || (mode == MODE_ENERGY && m < best)) begin
                    best = m;
                    pick = k;
                end
            end
            return pick;
        endfunction

        function void note(t_in_item it);
            t_out_item   r;
            int unsigned gone, k;
            logic [15:0] hop;
            logic        hit;
            r    = '0;
            gone = 0;
            hop  = 16'd0;
            case (it.action)
                ACT_INSERT: begin
                    if (n_paths >= CAPACITY) begin
                        r.rejected = 1'b1;
                    end else begin
                        paths[n_paths] = '{it.next_hop, it.last_hop, it.hop_count,
                            it.iface_addr, it.residual_energy, it.squared_distance,
                            it.path_delay};
                        n_paths++;
                        report(r, n_paths - 1);
                    end
                end
                ACT_FIND_NH, ACT_FIND_PR, ACT_FIND_LH: begin
                    for (k = 0; k < n_paths; k++) begin
                        if (it.action == ACT_FIND_NH) hit = paths[k].next_hop == it.next_hop;
                        else if (it.action == ACT_FIND_PR)
                            hit = paths[k].next_hop == it.next_hop
                                && paths[k].last_hop == it.last_hop;
                        else hit = paths[k].last_hop == it.next_hop;
                        if (hit) begin
                            report(r, k);
                            break;
                        end
                    end
                end
                ACT_DISJOINT: begin
                    r.found = 1'b1;
                    for (k = 0; k < n_paths; k++)
                        if (paths[k].next_hop == it.next_hop || paths[k].last_hop == it.last_hop)
                            r.found = 1'b0;
                end
                ACT_DEL_NH, ACT_DEL_IF: begin
                    k = 0;
                    while (k < n_paths) begin
                        if ((it.action == ACT_DEL_NH && paths[k].next_hop == it.next_hop) ||
                            (it.action == ACT_DEL_IF && paths[k].iface_addr == it.iface_addr)) begin
                            drop(k);
                            gone++;
                        end else begin
                            k++;
                        end
                    end
                end
                ACT_CLEAR: begin
                    gone    = n_paths;
                    n_paths = 0;
                end
                ACT_DEL_WST: begin
                    k = worst();
                    if (k < n_paths) begin
                        report(r, k);
                        drop(k);
                        gone = 1;
                    end
                end
                ACT_TRIM: begin
                    while (n_paths > keep) begin
                        k = worst();
                        if (k >= n_paths) break;
                        drop(k);
                        gone++;
                    end
                end
                ACT_MINHOP_P: begin
                    hop = HOP_CEIL;
                    for (k = 0; k < n_paths; k++)
                        if (paths[k].hop_count < hop) begin
                            hop = paths[k].hop_count;
                            report(r, k);
                        end
                    hop = 16'd0;
                end
                ACT_MAX_HOPS: begin
                    for (k = 0; k < n_paths; k++)
                        if (paths[k].hop_count > hop) hop = paths[k].hop_count;
                    if (hop == 16'd0) hop = NO_ROUTE_HOPS;
                end
                ACT_MIN_HOPS: begin
                    hop = NO_ROUTE_HOPS;
                    for (k = 0; k < n_paths; k++)
                        if (paths[k].hop_count < hop) hop = paths[k].hop_count;
                end
                default: ;
            endcase
            r.path_count    = n_paths[3:0];
            r.hop_result    = hop;
            r.removed_count = gone[3:0];
            pending = {pending, r};
        endfunction

        function void cmp(string name, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("found", e.found, got.found);
            cmp("slot", e.slot, got.slot);
            cmp("out_next_hop", e.out_next_hop, got.out_next_hop);
            cmp("out_last_hop", e.out_last_hop, got.out_last_hop);
            cmp("out_hop_count", e.out_hop_count, got.out_hop_count);
            cmp("out_energy", e.out_energy, got.out_energy);
            cmp("out_distance", e.out_distance, got.out_distance);
            cmp("out_delay", e.out_delay, got.out_delay);
            cmp("path_count", e.path_count, got.path_count);
            cmp("hop_result", e.hop_result, got.hop_result);
            cmp("rejected", e.rejected, got.rejected);
            cmp("removed_count", e.removed_count, got.removed_count);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_strobe;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    path_list_tracker tracker;
    int unsigned      cycles;
    int unsigned      idle_pct;

    multipath_path_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) tracker.note(i_item);
        if (i_rst_n && o_strobe) tracker.check(o_item);
    end

    task automatic reg_write(logic addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_cfg(addr, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // hold off new items until every result is back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send(t_in_item it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return $urandom();
            default: return 32'h0a00_0000 | $urandom_range(3);
        endcase
    endfunction

    function automatic logic [15:0] pick_hops();
        case ($urandom_range(6))
            0: return 16'd0;
            1: return 16'hffff;
            2: return NO_ROUTE_HOPS - 16'd1 + 16'($urandom_range(2));
            3: return 16'($urandom());
            default: return 16'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [31:0] pick_metric();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 38) it.action = ACT_INSERT;
        else if (r < 97) it.action = 4'($urandom_range(ACT_FIND_NH, ACT_MIN_HOPS));
        else it.action = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        // keep clears rare so the list has a chance to fill
        if (it.action == ACT_CLEAR && $urandom_range(3) != 0) it.action = ACT_INSERT;
        it.next_hop         = pick_addr();
        it.last_hop         = pick_addr();
        it.hop_count        = pick_hops();
        it.iface_addr       = pick_addr();
        it.residual_energy  = pick_metric();
        it.squared_distance = pick_metric();
        it.path_delay       = ($urandom_range(4) == 0) ? 64'd0 : {$urandom(), $urandom()};
        return it;
    endfunction

    initial begin
        t_in_item it;
        tracker  = new();
        cycles   = 0;
        idle_pct = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reg_write(REG_MODE, MODE_DIST);
        reg_write(REG_MAXP, 32'd3);

        // directed: empty list queries, fill past capacity, extremes, all actions
        for (int a = ACT_FIND_NH; a <= ACT_MIN_HOPS; a++) begin
            it = '0;
            it.action = 4'(a);
            send(it);
        end
        for (int n = 0; n < CAPACITY + 1; n++) begin
            it = '1;
            it.action    = ACT_INSERT;
            it.next_hop  = (n == 0) ? 32'd0 : 32'hffff_ffff - n;
            it.last_hop  = 32'd100 + n;
            it.hop_count = (n < 2) ? 16'd0 : (n == 2) ? 16'hffff : 16'(n);
            it.squared_distance = (n < 2) ? 32'd0 : 32'hffff_ffff;
            it.path_delay = (n == 1) ? 64'd0 : 64'hffff_ffff_ffff_ffff;
            send(it);
        end
        for (int a = ACT_FIND_NH; a <= ACT_SPARE_HI; a++) begin
            if (a == ACT_CLEAR || a == ACT_DEL_IF) continue;
            it = '0;
            it.action   = 4'(a);
            it.next_hop = 32'd0;
            it.last_hop = 32'd100;
            send(it);
        end
        drain();
        // zero metrics survive a trim to nothing
        reg_write(REG_MAXP, 32'd0);
        it = '0;
        it.action = ACT_TRIM;
        send(it);
        it.action = ACT_DEL_WST;
        send(it);
        it = '1;
        it.action = ACT_DEL_IF;
        send(it);
        it = '0;
        it.action = ACT_CLEAR;
        send(it);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            reg_write(REG_MODE, 32'(ph));
            reg_write(REG_MAXP, (ph == 0) ? 32'd1 : (ph == 1) ? 32'd8 : (ph == 2) ? 32'd0
                                : 32'($urandom_range(1, 8)));
            idle_pct = (ph == 1) ? 76 : (ph == 3) ? 29 : 0;
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if (n == ITEMS_PHASE / 2) drain();
                send(rand_item());
            end
        end

        start <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
